FILE: sv/assert_macros.svh
// Assertion macros shared by the ellipse rasterizer RTL.
// Expects a clock named clk and an active-low synchronous reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ELR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ELR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/elr_pkg.sv
// Shared widths, command and state types for the ellipse rasterizer.
// No dependencies; imported by every module of the block.
package elr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int AXIS_BITS   = 11;
  localparam int COLOR_BITS  = 32;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int SQ_BITS     = 2 * AXIS_BITS;
  localparam int SX_BITS     = COORD_BITS + 1;
  localparam int SY_BITS     = AXIS_BITS + 2;
  localparam int P_BITS      = SQ_BITS + SX_BITS + 2;
  localparam int DEC_BITS    = 3 * AXIS_BITS + 9;
  localparam int WK_BITS     = DEC_BITS + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] PIX_FIRST = 2'd0;
  localparam logic [1:0] PIX_LAST  = 2'd3;

  typedef enum logic [1:0] {
    CMD_DOT,
    CMD_ELLIPSE,
    CMD_STEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic [AXIS_BITS-1:0]    a;
    logic [AXIS_BITS-1:0]    b;
    logic [COLOR_BITS-1:0]   color;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_MOVE,
    ST_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    EM_DOT,
    EM_AXIS,
    EM_STEP
  } emit_mode_t;

endpackage

FILE: sv/elr_cmd_queue.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on elr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module elr_cmd_queue
  import elr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  input  logic [AXIS_BITS-1:0]  in_semi_a,
  input  logic [AXIS_BITS-1:0]  in_semi_b,
  input  logic [COLOR_BITS-1:0] in_pixel_color,
  output logic                  q_valid,
  input  logic                  q_ready,
  output cmd_t                  q_cmd
);

  cmd_t                entry_r [QUEUE_DEPTH];
  cmd_t                wr_cmd;
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign in_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_cmd    = entry_r[rd_ptr_r];

  // Classify once here so the engine only dispatches.
  always_comb begin
    wr_cmd.cx    = in_center_x;
    wr_cmd.cy    = in_center_y;
    wr_cmd.a     = in_semi_a;
    wr_cmd.b     = in_semi_b;
    wr_cmd.color = in_pixel_color;
    if (in_opcode == OP_STEP) begin
      wr_cmd.kind = CMD_STEP;
    end else if (in_semi_a == '0 && in_semi_b == '0) begin
      wr_cmd.kind = CMD_DOT;
    end else begin
      wr_cmd.kind = CMD_ELLIPSE;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

  `ELR_ASSERT_NXT(a_q_push_grows, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")
  `ELR_ASSERT_NXT(a_q_idle_holds, !push && !pop, $stable(count_r) && $stable(rd_ptr_r), "queue moved without a transaction")

endmodule

FILE: sv/elr_engine.sv
// Back end: runs the ellipse walk and emits pixels through an output register.
// Depends on elr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module elr_engine
  import elr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  cmd_t                       q_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_px,
  output logic signed [OUT_BITS-1:0] out_py,
  output logic [COLOR_BITS-1:0]      out_color,
  output logic                       out_last,
  output logic                       out_finished
);

  eng_state_t                  state_r, state_nxt;
  emit_mode_t                  mode_r, mode_nxt;
  logic                        active_r, active_nxt;
  logic                        done_r, done_nxt;
  logic [1:0]                  pix_r, pix_nxt;
  logic [COORD_BITS-1:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic [AXIS_BITS-1:0]        a_r, a_nxt;
  logic [SQ_BITS-1:0]          asq_r, asq_nxt, bsq_r, bsq_nxt;
  logic [SX_BITS-1:0]          sx_r, sx_nxt;
  logic signed [SY_BITS-1:0]   sy_r, sy_nxt;
  logic signed [DEC_BITS-1:0]  dec_r, dec_nxt;
  logic [COLOR_BITS-1:0]       color_r, color_nxt;
  logic signed [P_BITS-1:0]    pa_r, pa_nxt, pb_r, pb_nxt;

  logic                        out_valid_r;
  logic signed [OUT_BITS-1:0]  out_px_r, out_py_r;
  logic [COLOR_BITS-1:0]       out_color_r;
  logic                        out_last_r, out_finished_r;

  logic                        pop, out_free, load;
  logic [1:0]                  last_idx;
  logic signed [P_BITS-1:0]    pa_prod, pb_prod;
  logic signed [SQ_BITS:0]     init_diff;
  logic signed [DEC_BITS-1:0]  init_prod;
  logic signed [WK_BITS-1:0]   dw, paw, pbw, aw, bw, t_neg, t_pos, d_h, d_v, d_d;
  logic                        move_h, move_v;
  logic [SX_BITS-1:0]          sx_inc;
  logic signed [SY_BITS-1:0]   sy_dec, sy_mv;
  logic [OUT_BITS-1:0]         dx, dy, xs, ys, ax, by;
  logic                        emit_fin;

  assign q_ready  = (state_r == ST_IDLE);
  assign pop      = q_valid && q_ready;
  assign out_free = !out_valid_r || out_ready;
  assign load     = (state_r == ST_EMIT) && out_free;
  assign last_idx = (mode_r == EM_DOT) ? PIX_FIRST : PIX_LAST;

  // Products of the current position, formed when a step is taken off the queue.
  assign pa_prod = $signed({1'b0, asq_r}) * sy_r;
  assign pb_prod = $signed({1'b0, bsq_r}) * $signed({1'b0, sx_r});

  // Initial decision 2*B*(B - A*A); B sits in sy_r after the squares cycle.
  assign init_diff = (SQ_BITS + 1)'(sy_r) - $signed({1'b0, asq_r});
  assign init_prod = init_diff * sy_r;

  assign dw  = WK_BITS'(dec_r);
  assign paw = WK_BITS'(pa_r);
  assign pbw = WK_BITS'(pb_r);
  assign aw  = WK_BITS'($signed({1'b0, asq_r}));
  assign bw  = WK_BITS'($signed({1'b0, bsq_r}));

  assign t_neg = (dw <<< 1) + (paw <<< 1) - aw;
  assign t_pos = (dw <<< 1) - (pbw <<< 1) - bw;
  assign d_h   = dw + (pbw <<< 1) + (bw <<< 1) + bw;
  assign d_v   = dw - (paw <<< 1) + (aw <<< 1) + aw;
  assign d_d   = dw + (pbw <<< 1) - (paw <<< 1) + (aw <<< 1) + aw + (bw <<< 1) + bw;

  assign move_h = (dec_r < 0) && (t_neg < 0);
  assign move_v = (dec_r > 0) && (t_pos >= 0);
  assign sx_inc = sx_r + 1'b1;
  assign sy_dec = sy_r - $signed(SY_BITS'(1));
  assign sy_mv  = move_h ? sy_r : sy_dec;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            CMD_DOT:     state_nxt = ST_EMIT;
            CMD_ELLIPSE: state_nxt = ST_SQUARE;
            CMD_STEP:    state_nxt = active_r ? ST_MOVE : ST_IDLE;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQUARE: state_nxt = ST_INIT;
      ST_INIT:   state_nxt = ST_EMIT;
      ST_MOVE:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && pix_r == last_idx) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Walk datapath.
  always_comb begin
    mode_nxt   = mode_r;
    active_nxt = active_r;
    done_nxt   = done_r;
    pix_nxt    = pix_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    a_nxt      = a_r;
    asq_nxt    = asq_r;
    bsq_nxt    = bsq_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    dec_nxt    = dec_r;
    color_nxt  = color_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.kind)
            CMD_DOT: begin
              cx_nxt     = q_cmd.cx;
              cy_nxt     = q_cmd.cy;
              color_nxt  = q_cmd.color;
              a_nxt      = '0;
              asq_nxt    = '0;
              bsq_nxt    = '0;
              sx_nxt     = '0;
              sy_nxt     = '0;
              dec_nxt    = '0;
              active_nxt = 1'b0;
              mode_nxt   = EM_DOT;
            end
            CMD_ELLIPSE: begin
              cx_nxt     = q_cmd.cx;
              cy_nxt     = q_cmd.cy;
              color_nxt  = q_cmd.color;
              a_nxt      = q_cmd.a;
              sx_nxt     = '0;
              sy_nxt     = $signed(SY_BITS'(q_cmd.b));
              active_nxt = 1'b0;
            end
            CMD_STEP: begin
              pa_nxt = pa_prod;
              pb_nxt = pb_prod;
            end
            default: ;
          endcase
        end
      end
      ST_SQUARE: begin
        asq_nxt = a_r * a_r;
        bsq_nxt = sy_r[AXIS_BITS-1:0] * sy_r[AXIS_BITS-1:0];
      end
      ST_INIT: begin
        dec_nxt    = init_prod <<< 1;
        active_nxt = 1'b1;
        mode_nxt   = EM_AXIS;
      end
      ST_MOVE: begin
        if (move_h) begin
          sx_nxt  = sx_inc;
          dec_nxt = DEC_BITS'(d_h);
        end else if (move_v) begin
          sy_nxt  = sy_dec;
          dec_nxt = DEC_BITS'(d_v);
        end else begin
          sx_nxt  = sx_inc;
          sy_nxt  = sy_dec;
          dec_nxt = DEC_BITS'(d_d);
        end
        done_nxt   = (sy_mv < 0);
        active_nxt = !(sy_mv < 0);
        mode_nxt   = EM_STEP;
      end
      ST_EMIT: begin
        if (out_free) begin
          pix_nxt = (pix_r == last_idx) ? PIX_FIRST : pix_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Pixel offsets around the center, modulo the output width.
  assign xs = OUT_BITS'(sx_r);
  assign ys = OUT_BITS'(sy_r);
  assign ax = OUT_BITS'(a_r);
  assign by = OUT_BITS'(sy_r);

  always_comb begin
    dx       = '0;
    dy       = '0;
    emit_fin = 1'b0;
    case (mode_r)
      EM_DOT: begin
        emit_fin = 1'b1;
      end
      EM_AXIS: begin
        case (pix_r)
          2'd0:    dy = by;
          2'd1:    dy = -by;
          2'd2:    dx = ax;
          default: dx = -ax;
        endcase
      end
      EM_STEP: begin
        dx       = (pix_r == 2'd1 || pix_r == 2'd2) ? -xs : xs;
        dy       = (pix_r == 2'd2 || pix_r == 2'd3) ? -ys : ys;
        emit_fin = done_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      pix_r       <= PIX_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      pix_r       <= pix_nxt;
      out_valid_r <= load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    done_r  <= done_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    a_r     <= a_nxt;
    asq_r   <= asq_nxt;
    bsq_r   <= bsq_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    dec_r   <= dec_nxt;
    color_r <= color_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    if (load) begin
      out_px_r       <= $signed(OUT_BITS'(cx_r) + dx);
      out_py_r       <= $signed(OUT_BITS'(cy_r) + dy);
      out_color_r    <= color_r;
      out_last_r     <= (pix_r == last_idx);
      out_finished_r <= emit_fin;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_px       = out_px_r;
  assign out_py       = out_py_r;
  assign out_color    = out_color_r;
  assign out_last     = out_last_r;
  assign out_finished = out_finished_r;

  `ELR_ASSERT(a_eng_pix_idle, state_r != ST_EMIT, pix_r == PIX_FIRST, "pixel counter left mid-burst")
  `ELR_ASSERT(a_eng_move_active, state_r == ST_MOVE, active_r, "walk step taken on an idle ellipse")
  `ELR_ASSERT_NXT(a_eng_dec_hold, state_r == ST_EMIT, $stable(dec_r), "decision changed while emitting")
  `ELR_ASSERT(a_eng_out_src, $rose(out_valid_r), $past(state_r) == ST_EMIT, "output loaded outside emit")

endmodule

FILE: sv/ellipse_rasterizer.sv
// Top level of the ellipse rasterizer: command queue front end plus walk engine.
// Depends on elr_pkg, elr_cmd_queue and elr_engine.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | opcode, center_x, center_y, semi_a, semi_b,
//           |           |                       | pixel_color
//   out_    | output    | out_valid / out_ready | px, py, color, last, finished
//
// Step: dequeue and form the two position products, compare and move, then four pixels
// through the single output register at one per cycle while out_ready stays high.
// Start: dequeue, squares, initial decision, four pixels; zero-axis start: dequeue, one pixel;
// a step with no ellipse running is dropped at dequeue.
// Reset is synchronous; out_ready low holds the output register and the engine, and the
// two-entry command queue keeps taking transactions until it is full, then drops in_ready.

module ellipse_rasterizer
  import elr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [COORD_BITS-1:0]      in_center_x,
  input  logic [COORD_BITS-1:0]      in_center_y,
  input  logic [AXIS_BITS-1:0]       in_semi_a,
  input  logic [AXIS_BITS-1:0]       in_semi_b,
  input  logic [COLOR_BITS-1:0]      in_pixel_color,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] out_px,
  output logic signed [OUT_BITS-1:0] out_py,
  output logic [COLOR_BITS-1:0]      out_color,
  output logic                       out_last,
  output logic                       out_finished
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  elr_cmd_queue u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_semi_a      (in_semi_a),
    .in_semi_b      (in_semi_b),
    .in_pixel_color (in_pixel_color),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_cmd          (q_cmd)
  );

  elr_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_px       (out_px),
    .out_py       (out_py),
    .out_color    (out_color),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

FILE: test/tb_ellipse_rasterizer.sv
// Self-checking testbench for ellipse_rasterizer: queue-fed driver, pixel monitor, predictor.
// Depends on elr_pkg and the ellipse_rasterizer RTL; needs no files or arguments.
module tb_ellipse_rasterizer
  import elr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 300;
  localparam int IDLE_PCT     = 8;
  localparam int CALM_FIRST   = 1200;
  localparam int CALM_LAST    = 1800;
  localparam int HOLD_FIRST   = 700;
  localparam int HOLD_LAST    = 900;
  localparam int DRAIN_CYCLES = 30;
  localparam int WALK_CAP     = 5000;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [AXIS_BITS-1:0]  a;
    logic [AXIS_BITS-1:0]  b;
    logic [COLOR_BITS-1:0] color;
  } ellipse_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] px;
    logic signed [OUT_BITS-1:0] py;
    logic [COLOR_BITS-1:0]      color;
    logic                       last;
    logic                       finished;
  } pixel_t;

  // Walk position, squared axes and decision value of the running ellipse.
  typedef struct {
    longint                ox;
    longint                oy;
    longint                asq;
    longint                bsq;
    longint                sx;
    longint                sy;
    longint                dec;
    logic [COLOR_BITS-1:0] color;
    bit                    active;
  } walk_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_START;
  logic [COORD_BITS-1:0] in_center_x = '0;
  logic [COORD_BITS-1:0] in_center_y = '0;
  logic [AXIS_BITS-1:0] in_semi_a = '0;
  logic [AXIS_BITS-1:0] in_semi_b = '0;
  logic [COLOR_BITS-1:0] in_pixel_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] out_px;
  logic signed [OUT_BITS-1:0] out_py;
  logic [COLOR_BITS-1:0] out_color;
  logic out_last;
  logic out_finished;

  ellipse_req_t queued_cmds[$];
  pixel_t       pending_pixels[$];
  pixel_t       plan_scratch[$];
  walk_t        plan_walk = '{default: 0};
  walk_t        mirror_walk = '{default: 0};
  bit           in_acc = 1'b0;
  int           n_planned = 0;
  int           n_accepted = 0;
  int           n_starts = 0;
  int           n_dropped_steps = 0;
  int           n_completed = 0;
  int           n_checked = 0;
  int           n_errors = 0;

  ellipse_rasterizer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_semi_a      (in_semi_a),
    .in_semi_b      (in_semi_b),
    .in_pixel_color (in_pixel_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_px         (out_px),
    .out_py         (out_py),
    .out_color      (out_color),
    .out_last       (out_last),
    .out_finished   (out_finished)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pixel_t make_pixel(input walk_t w, input longint x, input longint y,
                                        input bit last, input bit fin);
    pixel_t p;
    p.px       = x[OUT_BITS-1:0];
    p.py       = y[OUT_BITS-1:0];
    p.color    = w.color;
    p.last     = last;
    p.finished = fin;
    return p;
  endfunction

  // Apply one transaction to the walk and append the pixels it produces.
  function automatic void rasterize_item(inout walk_t w, input ellipse_req_t req,
                                         ref pixel_t pq[$]);
    longint a;
    longint b;
    bit     fin;
    if (req.op == OP_START) begin
      a = longint'(req.a);
      b = longint'(req.b);
      w.ox    = longint'(req.cx);
      w.oy    = longint'(req.cy);
      w.color = req.color;
      if (a == 0 && b == 0) begin
        w.active = 1'b0;
        w.asq    = 0;
        w.bsq    = 0;
        w.sx     = 0;
        w.sy     = 0;
        w.dec    = 0;
        pq.push_back(make_pixel(w, w.ox, w.oy, 1'b1, 1'b1));
        return;
      end
      w.asq    = a * a;
      w.bsq    = b * b;
      w.sx     = 0;
      w.sy     = b;
      w.dec    = 2 * b * (b - w.asq);
      w.active = 1'b1;
      pq.push_back(make_pixel(w, w.ox, w.oy + b, 1'b0, 1'b0));
      pq.push_back(make_pixel(w, w.ox, w.oy - b, 1'b0, 1'b0));
      pq.push_back(make_pixel(w, w.ox + a, w.oy, 1'b0, 1'b0));
      pq.push_back(make_pixel(w, w.ox - a, w.oy, 1'b1, 1'b0));
      return;
    end
    if (!w.active) return;
    // Pick horizontal, vertical or diagonal move from the decision value.
    if (w.dec < 0 && (2 * w.dec + 2 * w.asq * w.sy - w.asq) < 0) begin
      w.sx  = w.sx + 1;
      w.dec = w.dec + 2 * w.bsq * w.sx + w.bsq;
    end else if (w.dec > 0 && (2 * w.dec - 2 * w.bsq * w.sx - w.bsq) >= 0) begin
      w.sy  = w.sy - 1;
      w.dec = w.dec - 2 * w.asq * w.sy + w.asq;
    end else begin
      w.sx  = w.sx + 1;
      w.sy  = w.sy - 1;
      w.dec = w.dec + 2 * w.bsq * w.sx - 2 * w.asq * w.sy + w.asq + w.bsq;
    end
    fin = (w.sy < 0);
    if (fin) w.active = 1'b0;
    pq.push_back(make_pixel(w, w.ox + w.sx, w.oy + w.sy, 1'b0, fin));
    pq.push_back(make_pixel(w, w.ox - w.sx, w.oy + w.sy, 1'b0, fin));
    pq.push_back(make_pixel(w, w.ox - w.sx, w.oy - w.sy, 1'b0, fin));
    pq.push_back(make_pixel(w, w.ox + w.sx, w.oy - w.sy, 1'b1, fin));
  endfunction

  // Queue a transaction and track the walk, so that sequences know when the ellipse closes.
  task automatic queue_cmd(input logic op, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy, input logic [AXIS_BITS-1:0] a,
                           input logic [AXIS_BITS-1:0] b, input logic [COLOR_BITS-1:0] color);
    ellipse_req_t req;
    req = '{op: op, cx: cx, cy: cy, a: a, b: b, color: color};
    queued_cmds.push_back(req);
    plan_scratch.delete();
    rasterize_item(plan_walk, req, plan_scratch);
    n_planned++;
  endtask

  // Step fields are ignored by the block; fill them with noise.
  task automatic queue_step();
    queue_cmd(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              AXIS_BITS'($urandom), AXIS_BITS'($urandom), $urandom);
  endtask

  task automatic queue_walk(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                            input logic [AXIS_BITS-1:0] a, input logic [AXIS_BITS-1:0] b,
                            input logic [COLOR_BITS-1:0] color, input int max_steps);
    queue_cmd(OP_START, cx, cy, a, b, color);
    for (int i = 0; i < max_steps && plan_walk.active; i++) queue_step();
  endtask

  task automatic build_stimulus();
    int pick;
    int cut;
    queue_step();
    queue_cmd(OP_START, '0, '0, '0, '0, '0);
    queue_cmd(OP_START, '1, '1, '0, '0, '1);
    queue_step();
    queue_walk('0, '0, '1, '1, 32'hFFFF_FFFF, 2);
    queue_walk('1, '1, '1, '0, 32'h8040_2010, WALK_CAP);
    queue_step();
    queue_walk(12'd100, 12'd200, 11'd0, 11'd5, 32'h00FF_00FF, WALK_CAP);
    queue_walk(12'd2000, 12'd10, 11'd3, 11'd2, 32'h1234_5678, WALK_CAP);
    queue_walk(12'd50, 12'd60, 11'd4, 11'd3, 32'hCAFE_0001, 2);
    queue_walk(12'd70, 12'd80, 11'd1, 11'd1, 32'h0F0F_0F0F, WALK_CAP);
    while (n_planned < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        cut = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : WALK_CAP;
        queue_walk(COORD_BITS'($urandom), COORD_BITS'($urandom),
                   AXIS_BITS'($urandom_range(0, 20)), AXIS_BITS'($urandom_range(0, 20)),
                   $urandom, cut);
      end else if (pick < 85) begin
        queue_walk(COORD_BITS'($urandom), COORD_BITS'($urandom),
                   AXIS_BITS'($urandom_range(0, 2047)), AXIS_BITS'($urandom_range(0, 2047)),
                   $urandom, $urandom_range(0, 6));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_cmd(1'($urandom_range(1)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                    AXIS_BITS'($urandom), AXIS_BITS'($urandom), $urandom);
      end
    end
  endtask

  // Driver: advance to the next transaction once the current one is taken.
  always @(negedge clk) begin : drive_proc
    ellipse_req_t req;
    int           tx_cycle;
    bit           calm;
    tx_cycle = tx_cycle + 1;
    calm = (tx_cycle >= CALM_FIRST && tx_cycle < CALM_LAST);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (queued_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        req = queued_cmds.pop_front();
        in_valid       <= 1'b1;
        in_opcode      <= req.op;
        in_center_x    <= req.cx;
        in_center_y    <= req.cy;
        in_semi_a      <= req.a;
        in_semi_b      <= req.b;
        in_pixel_color <= req.color;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, a stall-free stretch.
  always @(negedge clk) begin : accept_proc
    int rx_cycle;
    rx_cycle = rx_cycle + 1;
    if (!rst_n)
      out_ready <= 1'b0;
    else if (rx_cycle >= HOLD_FIRST && rx_cycle < HOLD_LAST)
      out_ready <= 1'b0;
    else if (rx_cycle >= CALM_FIRST && rx_cycle < CALM_LAST)
      out_ready <= 1'b1;
    else
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk) begin : monitor_proc
    ellipse_req_t req;
    pixel_t       want;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      req = '{op: in_opcode, cx: in_center_x, cy: in_center_y, a: in_semi_a,
              b: in_semi_b, color: in_pixel_color};
      n_accepted++;
      if (req.op == OP_START) n_starts++;
      else if (!mirror_walk.active) n_dropped_steps++;
      rasterize_item(mirror_walk, req, pending_pixels);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel px=%0d py=%0d", out_px, out_py);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (want.last && want.finished) n_completed++;
        if (out_px !== want.px) begin
          $error("px: expected %0d, got %0d", want.px, out_px);
          n_errors++;
        end
        if (out_py !== want.py) begin
          $error("py: expected %0d, got %0d", want.py, out_py);
          n_errors++;
        end
        if (out_color !== want.color) begin
          $error("out_color: expected %h, got %h", want.color, out_color);
          n_errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          n_errors++;
        end
        if (out_finished !== want.finished) begin
          $error("finished: expected %0b, got %0b", want.finished, out_finished);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    while (queued_cmds.size() != 0 || in_valid) @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    // Keep watching the output to catch stray pixels.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", pending_pixels.size());
      n_errors++;
    end
    $display("Sent %0d transactions (%0d starts, %0d steps dropped while idle).",
             n_accepted, n_starts, n_dropped_steps);
    $display("Checked %0d pixels; %0d ellipses closed; %0d mismatches.",
             n_checked, n_completed, n_errors);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
